### design/compute_invocation_id_generator_defines.svh
// ----------------------------------------------------------------------------
// Compute invocation ID generator: assertion macros
// Short forms for the concurrent checks; each expects clk in scope, and the masked forms also rst_n.
// ----------------------------------------------------------------------------
`ifndef COMPUTE_INVOCATION_ID_GENERATOR_DEFINES_SVH
`define COMPUTE_INVOCATION_ID_GENERATOR_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define CIG_CHECK_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");

// Next-cycle implication, masked while reset is low.
`define CIG_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");

// Next-cycle implication that also runs through reset.
`define CIG_CHECK_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

### design/cig_pkg.sv
// ----------------------------------------------------------------------------
// cig_pkg
// Shared widths, register indexes, state and bundle types, width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cig_pkg;

  localparam int LANES_DEF   = 4;
  localparam int GRP_W       = 16;
  localparam int SG_W        = 8;
  localparam int SXY_W       = 11;
  localparam int SZ_W        = 7;
  localparam int LOC_W       = 10;
  localparam int GLB_W       = 32;
  localparam int PXY_W       = GRP_W + SXY_W;
  localparam int PZ_W        = GRP_W + SZ_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SXY_W;
  localparam int DIV_STEPS   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIVX,
    FR_DIVY,
    FR_FULL
  } front_state_t;

  typedef struct packed {
    logic [SXY_W-1:0] size_x;
    logic [SXY_W-1:0] size_y;
    logic [SZ_W-1:0]  size_z;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // linear index width: subgroup number times lanes plus lane
  function automatic int idx_w(input int lanes);
    return SG_W + $clog2(lanes);
  endfunction

  function automatic int lane_w(input int lanes);
    return (lanes > 1) ? $clog2(lanes) : 1;
  endfunction

  // queue word: index, three local IDs, three group products
  function automatic int ent_w(input int lanes);
    return 4 * idx_w(lanes) + 2 * PXY_W + PZ_W;
  endfunction

endpackage

`default_nettype wire

### design/cig_div.sv
// ----------------------------------------------------------------------------
// cig_div
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cig_div #(
  parameter int DVD_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [DVD_W-1:0]          dividend,
  input  logic [cig_pkg::SXY_W-1:0] divisor,
  output logic                      done,
  output logic [DVD_W-1:0]          quo,
  output logic [DVD_W-1:0]          rem
);
  import cig_pkg::*;

  localparam int CYC   = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_W = CYC * DIV_STEPS;
  localparam int REM_W = SXY_W + 1;
  localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PAD_W-1:0] q_r, q_nxt, q_step;
  logic [REM_W-1:0] rem_r, rem_nxt, rem_step, sh;
  logic [DVD_W-1:0] dvd_r;
  logic [SXY_W-1:0] dsr_r;
  logic             last;

  // one batch of shift-compare-subtract steps
  always_comb begin
    q_step   = q_r;
    rem_step = rem_r;
    sh       = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      sh     = {rem_step[REM_W-2:0], q_step[PAD_W-1]};
      q_step = {q_step[PAD_W-2:0], 1'b0};
      if (sh >= {1'b0, dsr_r}) begin
        rem_step  = sh - {1'b0, dsr_r};
        q_step[0] = 1'b1;
      end else begin
        rem_step = sh;
      end
    end
  end

  assign last = busy_r && (cnt_r == CNT_W'(CYC - 1));

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      q_nxt   = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // results show in the finishing cycle and hold afterwards; zero divisor
  // gives quotient zero and hands back the dividend
  assign done = last;
  assign quo  = (dsr_r == '0) ? '0 : DVD_W'(q_nxt);
  assign rem  = (dsr_r == '0) ? dvd_r : DVD_W'(rem_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= PAD_W'(dividend);
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

### design/cig_fifo.sv
// ----------------------------------------------------------------------------
// cig_fifo
// Small register queue between the decompose front and the lane sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cig_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = cig_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [W-1:0]     wr_data,
  input  logic             pop,
  output logic [W-1:0]     rd_data,
  output cig_pkg::q_stat_t stat
);
  import cig_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### design/cig_front.sv
// ----------------------------------------------------------------------------
// cig_front
// Accept a subgroup, split its first index into x, y, z by two divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module cig_front #(
  parameter int LANES = cig_pkg::LANES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cig_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cig_pkg::GRP_W-1:0]            in_group_x,
  input  logic [cig_pkg::GRP_W-1:0]            in_group_y,
  input  logic [cig_pkg::GRP_W-1:0]            in_group_z,
  input  logic [cig_pkg::SG_W-1:0]             in_subgroup_number,
  input  cig_pkg::q_stat_t                     q_stat,
  output logic                                 q_push,
  output logic [cig_pkg::ent_w(LANES)-1:0]     q_data
);
  import cig_pkg::*;

  localparam int IDX_W = idx_w(LANES);

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] lx;
    logic [IDX_W-1:0] ly;
    logic [IDX_W-1:0] lz;
    logic [PXY_W-1:0] px;
    logic [PXY_W-1:0] py;
    logic [PZ_W-1:0]  pz;
  } ent_t;

  front_state_t     st_r, st_nxt;
  logic             accept;
  logic             div_load, div_done;
  logic [IDX_W-1:0] div_dvd, div_quo, div_rem;
  logic [SXY_W-1:0] div_dsr;
  logic [IDX_W-1:0] idx_r, lx_r;
  logic [PXY_W-1:0] px_r, py_r;
  logic [PZ_W-1:0]  pz_r;
  ent_t             ent;

  cig_div #(
    .DVD_W (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // first pass: index / size_x gives local x; second: that quotient / size_y
  // gives local y (remainder) and local z (quotient)
  always_comb begin
    st_nxt   = st_r;
    q_push   = 1'b0;
    in_ready = 1'b0;
    div_load = 1'b0;
    div_dvd  = IDX_W'(in_subgroup_number) * IDX_W'(LANES);
    div_dsr  = cfg.size_x;
    unique case (st_r)
      FR_IDLE: begin
        in_ready = 1'b1;
      end
      FR_DIVX: begin
        if (div_done) begin
          div_load = 1'b1;
          div_dvd  = div_quo;
          div_dsr  = cfg.size_y;
          st_nxt   = FR_DIVY;
        end
      end
      FR_DIVY: begin
        if (div_done) begin
          if (!q_stat.full) begin
            q_push   = 1'b1;
            in_ready = 1'b1;
            st_nxt   = FR_IDLE;
          end else begin
            st_nxt = FR_FULL;
          end
        end
      end
      FR_FULL: begin
        if (!q_stat.full) begin
          q_push   = 1'b1;
          in_ready = 1'b1;
          st_nxt   = FR_IDLE;
        end
      end
      default: begin
        st_nxt = FR_IDLE;
      end
    endcase
    accept = in_valid && in_ready;
    if (accept) begin
      div_load = 1'b1;
      st_nxt   = FR_DIVX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= div_dvd;
      px_r  <= PXY_W'(in_group_x) * PXY_W'(cfg.size_x);
      py_r  <= PXY_W'(in_group_y) * PXY_W'(cfg.size_y);
      pz_r  <= PZ_W'(in_group_z) * PZ_W'(cfg.size_z);
    end
    if ((st_r == FR_DIVX) && div_done) begin
      lx_r <= div_rem;
    end
  end

  assign ent.idx = idx_r;
  assign ent.lx  = lx_r;
  assign ent.ly  = div_rem;
  assign ent.lz  = div_quo;
  assign ent.px  = px_r;
  assign ent.py  = py_r;
  assign ent.pz  = pz_r;
  assign q_data  = ent;

endmodule

`default_nettype wire

### design/cig_back.sv
// ----------------------------------------------------------------------------
// cig_back
// Walk the lanes of one queued subgroup, one registered result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cig_back #(
  parameter int LANES = cig_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cig_pkg::cfg_t                       cfg,
  input  cig_pkg::q_stat_t                    q_stat,
  input  logic [cig_pkg::ent_w(LANES)-1:0]    q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cig_pkg::lane_w(LANES)-1:0]   out_lane,
  output logic [cig_pkg::LOC_W-1:0]           out_local_index,
  output logic [cig_pkg::LOC_W-1:0]           out_local_x,
  output logic [cig_pkg::LOC_W-1:0]           out_local_y,
  output logic [cig_pkg::LOC_W-1:0]           out_local_z,
  output logic [cig_pkg::GLB_W-1:0]           out_global_x,
  output logic [cig_pkg::GLB_W-1:0]           out_global_y,
  output logic [cig_pkg::GLB_W-1:0]           out_global_z,
  output logic                                out_active,
  output logic                                out_last_lane
);
  import cig_pkg::*;

  localparam int IDX_W  = idx_w(LANES);
  localparam int LANE_W = lane_w(LANES);
  localparam int CMP_W  = (IDX_W + 1 > SXY_W) ? IDX_W + 1 : SXY_W;
  localparam int AZ_W   = (IDX_W > SZ_W) ? IDX_W : SZ_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] lx;
    logic [IDX_W-1:0] ly;
    logic [IDX_W-1:0] lz;
    logic [PXY_W-1:0] px;
    logic [PXY_W-1:0] py;
    logic [PZ_W-1:0]  pz;
  } ent_t;

  ent_t              ent;
  logic              busy_r;
  logic [LANE_W-1:0] lane_r;
  logic [IDX_W-1:0]  idx_r, lx_r, ly_r, lz_r;
  logic [IDX_W-1:0]  lx_nxt, ly_nxt, lz_nxt;
  logic [PXY_W-1:0]  px_r, py_r;
  logic [PZ_W-1:0]   pz_r;
  logic              emit, last, wrap_x, wrap_y, active;

  logic              out_valid_r;
  logic [LANE_W-1:0] out_lane_r;
  logic [LOC_W-1:0]  out_idx_r, out_lx_r, out_ly_r, out_lz_r;
  logic [GLB_W-1:0]  out_gx_r, out_gy_r, out_gz_r;
  logic              out_active_r, out_last_r;

  assign ent = q_data;

  assign emit  = busy_r && (!out_valid_r || out_ready);
  assign last  = (lane_r == LANE_W'(LANES - 1));
  assign q_pop = q_stat.valid && (!busy_r || (emit && last));

  // step to the next index: bump x, carry into y, then into z
  assign wrap_x = ((CMP_W'(lx_r) + CMP_W'(1)) == CMP_W'(cfg.size_x));
  assign wrap_y = ((CMP_W'(ly_r) + CMP_W'(1)) == CMP_W'(cfg.size_y));

  always_comb begin
    lx_nxt = lx_r + IDX_W'(1);
    ly_nxt = ly_r;
    lz_nxt = lz_r;
    if (wrap_x) begin
      lx_nxt = '0;
      if (wrap_y) begin
        ly_nxt = '0;
        lz_nxt = lz_r + IDX_W'(1);
      end else begin
        ly_nxt = ly_r + IDX_W'(1);
      end
    end
  end

  // lane is inside the workgroup when its z slice is below size_z
  // and the x-y plane is not empty
  assign active = (cfg.size_x != '0) && (cfg.size_y != '0) &&
                  (AZ_W'(lz_r) < AZ_W'(cfg.size_z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lane_r <= '0;
      idx_r  <= ent.idx;
      lx_r   <= ent.lx;
      ly_r   <= ent.ly;
      lz_r   <= ent.lz;
      px_r   <= ent.px;
      py_r   <= ent.py;
      pz_r   <= ent.pz;
    end else if (emit) begin
      lane_r <= lane_r + LANE_W'(1);
      idx_r  <= idx_r + IDX_W'(1);
      lx_r   <= lx_nxt;
      ly_r   <= ly_nxt;
      lz_r   <= lz_nxt;
    end
    if (emit) begin
      out_lane_r   <= lane_r;
      out_idx_r    <= LOC_W'(idx_r);
      out_lx_r     <= LOC_W'(lx_r);
      out_ly_r     <= LOC_W'(ly_r);
      out_lz_r     <= LOC_W'(lz_r);
      out_gx_r     <= GLB_W'(px_r) + GLB_W'(lx_r);
      out_gy_r     <= GLB_W'(py_r) + GLB_W'(ly_r);
      out_gz_r     <= GLB_W'(pz_r) + GLB_W'(lz_r);
      out_active_r <= active;
      out_last_r   <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lane        = out_lane_r;
  assign out_local_index = out_idx_r;
  assign out_local_x     = out_lx_r;
  assign out_local_y     = out_ly_r;
  assign out_local_z     = out_lz_r;
  assign out_global_x    = out_gx_r;
  assign out_global_y    = out_gy_r;
  assign out_global_z    = out_gz_r;
  assign out_active      = out_active_r;
  assign out_last_lane   = out_last_r;

endmodule

`default_nettype wire

### design/compute_invocation_id_generator.sv
// ----------------------------------------------------------------------------
// compute_invocation_id_generator
// Expand one subgroup of a workgroup into per-lane local and global IDs.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    group_x, group_y, group_z,
//                                        subgroup_number
//   out_     out  out_valid / out_ready  lane, local_index, local_x/y/z,
//                                        global_x/y/z, active, last_lane
//   cfg_     in   cfg_wr_en              cfg_index, cfg_data (no read-back)
//
// Each subgroup gives LANES results, one per cycle from the lane sequencer
// while the output is not stalled. The front divider makes two passes of
// five quotient bits per cycle and can take the next subgroup as it pushes
// the last one into the queue. Reset sets all three sizes to one and
// empties the queue; there is no clearing pass. A stalled output holds
// its result while the front keeps decomposing into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module compute_invocation_id_generator #(
  parameter int LANES = cig_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [cig_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cig_pkg::CFG_DATA_W-1:0]      cfg_data,
  // subgroup words in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cig_pkg::GRP_W-1:0]           in_group_x,
  input  logic [cig_pkg::GRP_W-1:0]           in_group_y,
  input  logic [cig_pkg::GRP_W-1:0]           in_group_z,
  input  logic [cig_pkg::SG_W-1:0]            in_subgroup_number,
  // lane words out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cig_pkg::lane_w(LANES)-1:0]   out_lane,
  output logic [cig_pkg::LOC_W-1:0]           out_local_index,
  output logic [cig_pkg::LOC_W-1:0]           out_local_x,
  output logic [cig_pkg::LOC_W-1:0]           out_local_y,
  output logic [cig_pkg::LOC_W-1:0]           out_local_z,
  output logic [cig_pkg::GLB_W-1:0]           out_global_x,
  output logic [cig_pkg::GLB_W-1:0]           out_global_y,
  output logic [cig_pkg::GLB_W-1:0]           out_global_z,
  output logic                                out_active,
  output logic                                out_last_lane
);
  import cig_pkg::*;

  localparam int ENT_W = ent_w(LANES);

  logic [SXY_W-1:0] size_x_r, size_y_r;
  logic [SZ_W-1:0]  size_z_r;
  cfg_t             cfg;

  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [ENT_W-1:0] q_wr_data, q_rd_data;

  // size registers; writes to an unknown index drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SXY_W'(1);
      size_y_r <= SXY_W'(1);
      size_z_r <= SZ_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data[SZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.size_x = size_x_r;
  assign cfg.size_y = size_y_r;
  assign cfg.size_z = size_z_r;

  // front: accept and decompose the subgroup's first index
  cig_front #(
    .LANES (LANES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_group_x         (in_group_x),
    .in_group_y         (in_group_y),
    .in_group_z         (in_group_z),
    .in_subgroup_number (in_subgroup_number),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_data             (q_wr_data)
  );

  // queue: lets the front run ahead while the output stalls
  cig_fifo #(
    .W     (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // back: advance lane by lane, carry the local IDs incrementally
  cig_back #(
    .LANES (LANES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_stat          (q_stat),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lane        (out_lane),
    .out_local_index (out_local_index),
    .out_local_x     (out_local_x),
    .out_local_y     (out_local_y),
    .out_local_z     (out_local_z),
    .out_global_x    (out_global_x),
    .out_global_y    (out_global_y),
    .out_global_z    (out_global_z),
    .out_active      (out_active),
    .out_last_lane   (out_last_lane)
  );

endmodule

`default_nettype wire

### design/cig_chk.sv
// ----------------------------------------------------------------------------
// cig_chk
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compute_invocation_id_generator_defines.svh"

module cig_chk #(
  parameter int LANES = cig_pkg::LANES_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cig_pkg::lane_w(LANES)-1:0]   out_lane,
  input logic [cig_pkg::LOC_W-1:0]           out_local_index,
  input logic [cig_pkg::GLB_W-1:0]           out_global_x,
  input logic                                out_last_lane
);
  import cig_pkg::*;

  localparam int LANE_W = lane_w(LANES);

  logic                   out_fire, out_stall, seq_ok;
  logic [LOC_W+GLB_W:0]   held_word;
  logic [LANE_W-1:0]      lane_inc_r;
  logic [LOC_W-1:0]       idx_inc_r;

  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign held_word = {out_local_index, out_global_x, out_last_lane};

  // lane and index one step on from the word seen at the last edge
  always_ff @(posedge clk) begin
    lane_inc_r <= out_lane + LANE_W'(1);
    idx_inc_r  <= out_local_index + LOC_W'(1);
  end

  assign seq_ok = out_valid && (out_lane == lane_inc_r) && (out_local_index == idx_inc_r);

  // a stalled word holds
  `CIG_CHECK_NEXT(a_out_hold, out_stall, out_valid && $stable(held_word))

  // lanes of one subgroup leave back to back with consecutive indexes
  `CIG_CHECK_NEXT(a_lane_seq, out_fire && !out_last_lane, seq_ok)

  // last-lane flag marks exactly the top lane
  `CIG_CHECK_NOW(a_last_lane, out_valid, out_last_lane == (out_lane == LANE_W'(LANES - 1)))

  // reset drops the output
  `CIG_CHECK_RST(a_rst_quiet, !rst_n, !out_valid)

endmodule

bind compute_invocation_id_generator cig_chk #(.LANES(LANES)) u_cig_chk (.*);

`default_nettype wire
